@@ rtl/core/raster_shape_draw_engine_top_macros.svh @@
// Assertion macros used by the checker file of the draw engine.
`ifndef RASTER_SHAPE_DRAW_ENGINE_TOP_MACROS_SVH
`define RASTER_SHAPE_DRAW_ENGINE_TOP_MACROS_SVH

// Same-cycle implication.
`define RSDE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RSDE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/rsde_pkg.sv @@
// Package: types, codes and constants of the raster shape draw engine.
package rsde_pkg;

  localparam int DEF_MAX_COLUMNS = 64;
  localparam int DEF_MAX_ROWS    = 64;
  localparam int COORD_W         = 10;
  localparam int CFG_W           = 7;
  localparam int ROW_BITS_W      = 64;

  localparam logic CFG_COLUMNS = 1'b0;
  localparam logic CFG_ROWS    = 1'b1;

  typedef enum logic [1:0] {
    ACT_SQUARE   = 2'd0,
    ACT_TRIANGLE = 2'd1,
    ACT_LINE     = 2'd2,
    ACT_READ     = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SQUARE,
    ST_TRI,
    ST_LINE,
    ST_READ,
    ST_RDWAIT,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]        action;
    logic signed [7:0] start_x;
    logic signed [7:0] start_y;
    logic signed [7:0] end_x;
    logic signed [7:0] end_y;
    logic [6:0]        shape_size;
    logic [1:0]        direction;
  } in_t;

  typedef struct packed {
    logic                  status;
    logic [ROW_BITS_W-1:0] row_bits;
  } out_t;

  // Request from the sequencer to the board memory.
  typedef struct packed {
    logic mark;
    logic fetch;
  } brd_cmd_t;

endpackage

@@ rtl/core/raster_shape_draw_engine_top.sv @@
// Top level of the raster shape draw engine: command sequencer and board.
//
// Input channel (in_valid / in_stall / in_data): one transaction is one
// command: square fill, right triangle fill, Bresenham line, or row read.
// Output channel (out_valid / out_stall / out_data): exactly one result
// transaction per command with a status and, for a row read, the row bits.
// Configuration: cfg_we / cfg_index / cfg_data set columns and rows in use;
// write only while the engine is idle.
// Timing: commands run one at a time. The board memory has a registered
// read; one board row (square, triangle) or one line pixel is issued per
// cycle, with write forwarding so back-to-back updates of the same row
// are merged. The next command can be taken in the cycle after the result
// is loaded.
// in_stall is high while a command is in flight; a new command is taken
// while the previous result still waits in the output register.
// A stalled result holds steady; the engine waits in its final state until
// the output register frees up.
// Reset: synchronous; the board reads as all unmarked at once (per-row
// valid flags), both registers return to 64, no result is pending.
module raster_shape_draw_engine_top #(
  parameter int MAX_COLUMNS = rsde_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = rsde_pkg::DEF_MAX_ROWS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  rsde_pkg::in_t             in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output rsde_pkg::out_t            out_data,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [rsde_pkg::CFG_W-1:0] cfg_data
);
  import rsde_pkg::*;

  localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam logic [CW-1:0] COL_TOP = CW'(MAX_COLUMNS - 1);

  typedef logic signed [COORD_W-1:0] crd_t;

  localparam crd_t C_ONE = crd_t'(1);

  state_t state, state_next;

  logic [CFG_W-1:0] board_columns, board_rows;
  logic [CFG_W-1:0] ucols, urows;
  crd_t             cols_s, rows_s;

  in_t  cmd;
  logic status_r, status_next;
  logic [MAX_COLUMNS-1:0] bits_r, bits_next;

  // walk registers
  crd_t       cur_y, cur_y_next;
  logic [6:0] cnt, cnt_next;
  crd_t       lx, ly, lerr, ldx, ldy, lstx, lsty;
  crd_t       lx_next, ly_next, lerr_next, ldx_next, ldy_next, lstx_next, lsty_next;

  crd_t x1, y1, x2, y2, sz;
  crd_t lo, hi, cy, jmax, kk, e2;
  logic [CW-1:0] lo_i, hi_i;
  logic [MAX_COLUMNS-1:0] span_mask, col_mask;

  brd_cmd_t               bcmd;
  logic [RW-1:0]          brow;
  logic [MAX_COLUMNS-1:0] rd_data;
  logic                   busy;

  function automatic logic oor(crd_t x, crd_t y, crd_t c, crd_t r);
    return (x < 0) || (x >= c) || (y < 0) || (y >= r);
  endfunction

  assign ucols  = (board_columns > CFG_W'(MAX_COLUMNS)) ? CFG_W'(MAX_COLUMNS) : board_columns;
  assign urows  = (board_rows > CFG_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : board_rows;
  assign cols_s = crd_t'({3'b000, ucols});
  assign rows_s = crd_t'({3'b000, urows});

  assign x1 = crd_t'(cmd.start_x);
  assign y1 = crd_t'(cmd.start_y);
  assign x2 = crd_t'(cmd.end_x);
  assign y2 = crd_t'(cmd.end_y);
  assign sz = crd_t'({3'b000, cmd.shape_size});

  // contiguous column span lo..hi
  assign lo_i      = lo[CW-1:0];
  assign hi_i      = hi[CW-1:0];
  assign span_mask = ({MAX_COLUMNS{1'b1}} << lo_i) & ({MAX_COLUMNS{1'b1}} >> (COL_TOP - hi_i));
  assign col_mask  = (ucols == '0) ? '0 :
                     ({MAX_COLUMNS{1'b1}} >> (CFG_W'(MAX_COLUMNS) - ucols));

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      board_columns <= CFG_W'(64);
      board_rows    <= CFG_W'(64);
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_COLUMNS: board_columns <= cfg_data;
          CFG_ROWS:    board_rows    <= cfg_data;
          default:     board_columns <= board_columns;
        endcase
      end
      if (state == ST_DONE && !(out_valid && out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd <= in_data;
    end
    if (state == ST_DONE && !(out_valid && out_stall)) begin
      out_data.status   <= status_r;
      out_data.row_bits <= ROW_BITS_W'(bits_r);
    end
    status_r <= status_next;
    bits_r   <= bits_next;
    cur_y    <= cur_y_next;
    cnt      <= cnt_next;
    lx       <= lx_next;
    ly       <= ly_next;
    lerr     <= lerr_next;
    ldx      <= ldx_next;
    ldy      <= ldy_next;
    lstx     <= lstx_next;
    lsty     <= lsty_next;
  end

  always_comb begin
    state_next  = state;
    status_next = status_r;
    bits_next   = bits_r;
    cur_y_next  = cur_y;
    cnt_next    = cnt;
    lx_next     = lx;
    ly_next     = ly;
    lerr_next   = lerr;
    ldx_next    = ldx;
    ldy_next    = ldy;
    lstx_next   = lstx;
    lsty_next   = lsty;
    bcmd        = '0;
    brow        = cur_y[RW-1:0];
    lo          = x1;
    hi          = x1;
    cy          = cur_y;
    jmax        = '0;
    kk          = '0;
    e2          = lerr <<< 1;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_CHECK;
        end
      end

      ST_CHECK: begin
        status_next = 1'b0;
        bits_next   = '0;
        cur_y_next  = y1;
        cnt_next    = '0;
        case (action_t'(cmd.action))
          ACT_SQUARE: begin
            cnt_next = cmd.shape_size;
            if (oor(x1, y1, cols_s, rows_s) ||
                oor(x1 + sz - C_ONE, y1 + sz - C_ONE, cols_s, rows_s)) begin
              status_next = 1'b1;
              state_next  = ST_DONE;
            end else if (cmd.shape_size == '0) begin
              state_next = ST_DONE;
            end else begin
              state_next = ST_SQUARE;
            end
          end
          ACT_TRIANGLE: begin
            if (oor(x1, y1, cols_s, rows_s)) begin
              status_next = 1'b1;
              state_next  = ST_DONE;
            end else if (cmd.shape_size == '0) begin
              state_next = ST_DONE;
            end else begin
              state_next = ST_TRI;
            end
          end
          ACT_LINE: begin
            lx_next   = x1;
            ly_next   = y1;
            ldx_next  = (x2 > x1) ? x2 - x1 : x1 - x2;
            ldy_next  = (y2 > y1) ? y2 - y1 : y1 - y2;
            lstx_next = (x1 < x2) ? crd_t'(1) : crd_t'(-1);
            lsty_next = (y1 < y2) ? crd_t'(1) : crd_t'(-1);
            lerr_next = ldx_next - ldy_next;
            if (oor(x1, y1, cols_s, rows_s) || oor(x2, y2, cols_s, rows_s)) begin
              status_next = 1'b1;
              state_next  = ST_DONE;
            end else begin
              state_next = ST_LINE;
            end
          end
          ACT_READ: begin
            if (oor(crd_t'(0), y1, cols_s, rows_s) || y1 >= crd_t'(MAX_ROWS)) begin
              status_next = 1'b1;
              state_next  = ST_DONE;
            end else begin
              state_next = ST_READ;
            end
          end
          default: state_next = ST_DONE;
        endcase
      end

      ST_SQUARE: begin
        lo        = x1;
        hi        = x1 + sz - C_ONE;
        bcmd.mark = 1'b1;
        cur_y_next = cur_y + C_ONE;
        cnt_next   = cnt - 7'd1;
        if (cnt == 7'd1) begin
          state_next = ST_DRAIN;
        end
      end

      ST_TRI: begin
        // cnt is the row index i; row sits size-1-i away from the apex
        cy   = cmd.direction[0] ? y1 + (sz - C_ONE - crd_t'({3'b000, cnt}))
                                : y1 - (sz - C_ONE - crd_t'({3'b000, cnt}));
        brow = cy[RW-1:0];
        jmax = cmd.direction[1] ? cols_s - C_ONE - x1 : x1;
        kk   = (crd_t'({3'b000, cnt}) > jmax) ? jmax : crd_t'({3'b000, cnt});
        lo   = cmd.direction[1] ? x1 : x1 - kk;
        hi   = cmd.direction[1] ? x1 + kk : x1;
        if (cy < 0 || cy >= rows_s) begin
          status_next = 1'b1;
          state_next  = ST_DRAIN;
        end else begin
          bcmd.mark = 1'b1;
          cnt_next  = cnt + 7'd1;
          if (crd_t'({3'b000, cnt}) > jmax) begin
            // partial row is kept, then the walk stops
            status_next = 1'b1;
            state_next  = ST_DRAIN;
          end else if (cnt == cmd.shape_size - 7'd1) begin
            state_next = ST_DRAIN;
          end
        end
      end

      ST_LINE: begin
        lo        = lx;
        hi        = lx;
        brow      = ly[RW-1:0];
        bcmd.mark = 1'b1;
        if (lx == x2 && ly == y2) begin
          state_next = ST_DRAIN;
        end else begin
          lerr_next = lerr;
          if (e2 > -ldy) begin
            lerr_next = lerr_next - ldy;
            lx_next   = lx + lstx;
          end
          if (e2 < ldx) begin
            lerr_next = lerr_next + ldx;
            ly_next   = ly + lsty;
          end
        end
      end

      ST_READ: begin
        bcmd.fetch = 1'b1;
        brow       = y1[RW-1:0];
        state_next = ST_RDWAIT;
      end

      ST_RDWAIT: begin
        bits_next  = rd_data & col_mask;
        state_next = ST_DONE;
      end

      ST_DRAIN: begin
        if (!busy) begin
          state_next = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!(out_valid && out_stall)) begin
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  rsde_board #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS),
    .RW         (RW)
  ) u_board (
    .clk    (clk),
    .rst    (rst),
    .cmd    (bcmd),
    .row    (brow),
    .mask   (span_mask),
    .rd_data(rd_data),
    .busy   (busy)
  );

endmodule

@@ rtl/core/rsde_board.sv @@
// Board memory with a read-modify-write stage and write forwarding.
module rsde_board #(
  parameter int MAX_COLUMNS = rsde_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = rsde_pkg::DEF_MAX_ROWS,
  parameter int RW          = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  rsde_pkg::brd_cmd_t     cmd,
  input  logic [RW-1:0]          row,
  input  logic [MAX_COLUMNS-1:0] mask,
  output logic [MAX_COLUMNS-1:0] rd_data,
  output logic                   busy
);
  import rsde_pkg::*;

  logic [MAX_COLUMNS-1:0] mem [MAX_ROWS];
  logic [MAX_ROWS-1:0]    row_valid;
  logic [MAX_COLUMNS-1:0] mem_q;
  logic                   q_vld;
  logic                   s1_mark;
  logic [RW-1:0]          s1_row;
  logic [MAX_COLUMNS-1:0] s1_mask;
  logic                   last_w;
  logic [RW-1:0]          last_row;
  logic [MAX_COLUMNS-1:0] last_data;
  logic [MAX_COLUMNS-1:0] base;

  // previous cycle's write is not yet visible in mem_q
  always_comb begin
    if (last_w && last_row == s1_row) begin
      base = last_data;
    end else if (q_vld) begin
      base = mem_q;
    end else begin
      base = '0;
    end
  end

  assign rd_data = base;
  assign busy    = s1_mark;

  always_ff @(posedge clk) begin
    if (cmd.mark || cmd.fetch) begin
      mem_q <= mem[row];
    end
    if (s1_mark) begin
      mem[s1_row] <= base | s1_mask;
    end
    s1_row    <= row;
    s1_mask   <= mask;
    last_row  <= s1_row;
    last_data <= base | s1_mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      q_vld     <= 1'b0;
      s1_mark   <= 1'b0;
      last_w    <= 1'b0;
    end else begin
      if (cmd.mark || cmd.fetch) begin
        q_vld <= row_valid[row];
      end
      if (s1_mark) begin
        row_valid[s1_row] <= 1'b1;
      end
      s1_mark <= cmd.mark;
      last_w  <= s1_mark;
    end
  end

endmodule

@@ rtl/core/rsde_checker.sv @@
// Port-level checker for the draw engine, bound to the top level.
`include "raster_shape_draw_engine_top_macros.svh"

module rsde_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input rsde_pkg::out_t out_data
);
  import rsde_pkg::*;

  `RSDE_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data), "result dropped or changed under stall")
  `RSDE_ASSERT_NXT(a_busy_after_take, clk, rst, in_valid && !in_stall, in_stall, "engine not busy after taking a command")
  `RSDE_ASSERT_IMP(a_reset_clean, clk, 1'b0, $past(rst), !out_valid && !in_stall, "result or busy right after reset")
  `RSDE_ASSERT_NXT(a_no_ghost, clk, rst, !in_stall && !(in_valid) && !out_valid, !out_valid, "result without a command")

endmodule

bind raster_shape_draw_engine_top rsde_checker u_rsde_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

@@ tb/raster_shape_draw_engine_top_tb.sv @@
// Self-checking testbench for the raster shape draw engine: directed table, then random commands.
`timescale 1ns / 1ps

module raster_shape_draw_engine_top_tb;
  import rsde_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000; // cycles with no transaction on any channel
  localparam int SETTLE_CYCLES  = 12;   // longer than a rejected command or a read
  localparam int ITEMS_PER_SET  = 108;

  logic  clk;
  logic  rst;
  logic  in_valid;
  logic  in_stall;
  in_t   in_data;
  logic  out_valid;
  logic  out_stall;
  out_t  out_data;
  logic  cfg_we;
  logic  cfg_index;
  logic [CFG_W-1:0] cfg_data;

  raster_shape_draw_engine_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Shadow of the engine: board bitmap and the two size registers.
  logic [63:0] shadow_board [64];
  logic [6:0]  shadow_cols;
  logic [6:0]  shadow_rows;

  out_t pending_results[$];  // results still owed by the engine, oldest first
  int   mismatches;
  int   quiet_cycles;
  bit   no_gaps;             // set for stretches without idle cycles
  int   resp_hold;           // stall cycles left before the next result is taken

  // Directed stimulus table; a row with known_result set carries its answer.
  typedef struct {
    in_t  cmd;
    bit   known_result;
    out_t result;
  } cmd_row_t;
  cmd_row_t directed_rows[$];

  function automatic int cols_in_use();
    return (shadow_cols > 64) ? 64 : int'(shadow_cols);
  endfunction

  function automatic int rows_in_use();
    return (shadow_rows > 64) ? 64 : int'(shadow_rows);
  endfunction

  function automatic bit off_board(int x, int y);
    return x < 0 || x >= cols_in_use() || y < 0 || y >= rows_in_use();
  endfunction

  function automatic void set_cell(int x, int y);
    if (x >= 0 && x < 64 && y >= 0 && y < 64) shadow_board[y][x] = 1'b1;
  endfunction

  // Applies one command to the shadow board and returns the result it owes.
  function automatic out_t draw_command(in_t c);
    out_t r;
    int x, y, x2, y2, sz, sgx, sgy, dx, dy, stx, sty, err, e2;
    bit fail;
    x = c.start_x;  y = c.start_y;
    x2 = c.end_x;   y2 = c.end_y;
    sz = c.shape_size;
    fail = 1'b0;
    r.row_bits = '0;
    case (action_t'(c.action))
      ACT_SQUARE: begin
        fail = off_board(x, y) || off_board(x + sz - 1, y + sz - 1);
        if (!fail)
          for (int i = y; i < y + sz; i++)
            for (int j = x; j < x + sz; j++) set_cell(j, i);
      end
      ACT_TRIANGLE: begin
        sgx = c.direction[1] ? 1 : -1;
        sgy = c.direction[0] ? 1 : -1;
        fail = off_board(x, y);
        // cells are visited in row order; a failing cell leaves earlier marks
        for (int i = 0; i < sz && !fail; i++)
          for (int j = 0; j <= i && !fail; j++) begin
            if (off_board(x + sgx * j, y + sgy * (sz - 1 - i))) fail = 1'b1;
            else set_cell(x + sgx * j, y + sgy * (sz - 1 - i));
          end
      end
      ACT_LINE: begin
        fail = off_board(x, y) || off_board(x2, y2);
        if (!fail) begin
          dx = (x2 > x) ? x2 - x : x - x2;
          dy = (y2 > y) ? y2 - y : y - y2;
          stx = (x < x2) ? 1 : -1;
          sty = (y < y2) ? 1 : -1;
          err = dx - dy;
          forever begin
            set_cell(x, y);
            if (x == x2 && y == y2) break;
            e2 = 2 * err;
            if (e2 > -dy) begin err -= dy; x += stx; end
            if (e2 < dx) begin err += dx; y += sty; end
          end
        end
      end
      default: begin
        fail = off_board(0, y) || y >= 64;
        if (!fail)
          r.row_bits = shadow_board[y] &
                       ((cols_in_use() >= 64) ? '1 : ((64'd1 << cols_in_use()) - 64'd1));
      end
    endcase
    r.status = fail;
    return r;
  endfunction

  function automatic in_t make_cmd(action_t a, int x, int y, int x2, int y2, int sz, int dir);
    in_t c;
    c.action = a;
    c.start_x = x[7:0];  c.start_y = y[7:0];
    c.end_x = x2[7:0];   c.end_y = y2[7:0];
    c.shape_size = sz[6:0];
    c.direction = dir[1:0];
    return c;
  endfunction

  function automatic void add_row(action_t a, int x, int y, int x2, int y2, int sz, int dir,
                                  bit known = 1'b0, bit st = 1'b0, logic [63:0] bits = '0);
    cmd_row_t row;
    row.cmd = make_cmd(a, x, y, x2, y2, sz, dir);
    row.known_result = known;
    row.result.status = st;
    row.result.row_bits = bits;
    directed_rows.push_back(row);
  endfunction

  // Coordinate near the used area, sometimes anywhere in the 8-bit range.
  function automatic int pick_coord(int span);
    if ($urandom_range(0, 9) == 0) return $signed(8'($urandom()));
    return int'($urandom_range(0, span + 1)) - 1;
  endfunction

  function automatic in_t random_cmd();
    int sel, sz;
    action_t a;
    sel = $urandom_range(0, 9);
    a = (sel < 2) ? ACT_SQUARE : (sel < 4) ? ACT_TRIANGLE : (sel < 7) ? ACT_LINE : ACT_READ;
    sel = $urandom_range(0, 19);
    sz = (sel < 14) ? $urandom_range(0, 8) : (sel < 19) ? $urandom_range(0, 24)
                                           : $urandom_range(0, 127);
    return make_cmd(a, pick_coord(cols_in_use()), pick_coord(rows_in_use()),
                    pick_coord(cols_in_use()), pick_coord(rows_in_use()),
                    sz, $urandom_range(0, 3));
  endfunction

  // Sends one command; the expectation is queued at the accepting edge.
  task automatic send_cmd(in_t c, bit known, out_t known_res);
    int gap;
    out_t predicted;
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = c;
    do @(posedge clk); while (in_stall);
    predicted = draw_command(c);
    pending_results.push_back(known ? known_res : predicted);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value[CFG_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_COLUMNS) shadow_cols = value[6:0];
    else shadow_rows = value[6:0];
  endtask

  // Result side: random stall before each result, checked field by field.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (resp_hold > 0) begin
      out_stall <= 1'b1;
      resp_hold <= resp_hold - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      resp_hold <= no_gaps ? 0 : $urandom_range(0, 19);
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected: status %0d row_bits %h",
               out_data.status, out_data.row_bits);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          mismatches++;
        end
        if (out_data.row_bits !== want.row_bits) begin
          $error("row_bits: expected %h, got %h", want.row_bits, out_data.row_bits);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: any transaction or config write restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    // register settings per random set: {columns, rows}; extremes included
    int reg_sets[10][2] = '{'{64, 64}, '{1, 1}, '{0, 12}, '{40, 0}, '{127, 127},
                            '{20, 37}, '{64, 9}, '{7, 64}, '{100, 3}, '{64, 64}};
    out_t dummy;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_COLUMNS;
    cfg_data = '0;
    out_stall = 1'b0;
    resp_hold = 0;
    mismatches = 0;
    quiet_cycles = 0;
    no_gaps = 1'b0;
    dummy = '0;
    foreach (shadow_board[i]) shadow_board[i] = '0;
    shadow_cols = 7'd64;
    shadow_rows = 7'd64;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, reset sizes 64 x 64.
    add_row(ACT_READ, 0, 0, 0, 0, 0, 0, 1, 0, '0);          // board clear after reset
    add_row(ACT_READ, 0, -1, 0, 0, 0, 0, 1, 1, '0);         // read above the board
    add_row(ACT_READ, 0, 64, 0, 0, 0, 0, 1, 1, '0);         // read below the board
    add_row(ACT_READ, 127, -128, -128, 127, 127, 3, 1, 1, '0);
    add_row(ACT_SQUARE, 0, 0, 0, 0, 1, 0, 1, 0, '0);        // single cell
    add_row(ACT_READ, 0, 0, 0, 0, 0, 0, 1, 0, 64'h1);
    add_row(ACT_SQUARE, 5, 5, 0, 0, 0, 0);                  // zero size, corner inside
    add_row(ACT_SQUARE, 0, 0, 0, 0, 0, 0, 1, 1, '0);        // zero size, corner at -1
    add_row(ACT_SQUARE, 60, 60, 0, 0, 4, 0);
    add_row(ACT_SQUARE, 61, 61, 0, 0, 4, 0, 1, 1, '0);      // far corner off the board
    add_row(ACT_SQUARE, 0, 0, 0, 0, 127, 0, 1, 1, '0);
    add_row(ACT_TRIANGLE, 30, 30, 0, 0, 5, 0);
    add_row(ACT_TRIANGLE, 30, 30, 0, 0, 5, 1);
    add_row(ACT_TRIANGLE, 30, 30, 0, 0, 5, 2);
    add_row(ACT_TRIANGLE, 30, 30, 0, 0, 5, 3);
    add_row(ACT_TRIANGLE, 2, 10, 0, 0, 6, 0);               // fails part way, marks stay
    add_row(ACT_TRIANGLE, -1, 0, 0, 0, 3, 3, 1, 1, '0);     // apex off the board
    add_row(ACT_TRIANGLE, 40, 40, 0, 0, 0, 2);
    add_row(ACT_LINE, 0, 0, 63, 63, 0, 0);
    add_row(ACT_LINE, 63, 0, 0, 20, 0, 0);
    add_row(ACT_LINE, 5, 5, 5, 5, 0, 0);
    add_row(ACT_LINE, 0, 0, 64, 0, 0, 0, 1, 1, '0);
    add_row(ACT_LINE, 10, 10, -128, 127, 127, 3, 1, 1, '0);
    add_row(ACT_READ, 0, 10, 0, 0, 0, 0);
    add_row(ACT_READ, 0, 63, 0, 0, 0, 0);
    foreach (directed_rows[i])
      send_cmd(directed_rows[i].cmd, directed_rows[i].known_result, directed_rows[i].result);

    // Random sets, each under its own register values and idle pattern.
    foreach (reg_sets[s]) begin
      wait_idle();
      write_reg(CFG_COLUMNS, reg_sets[s][0]);
      write_reg(CFG_ROWS, reg_sets[s][1]);
      no_gaps = (s % 4 == 3);
      repeat (ITEMS_PER_SET) send_cmd(random_cmd(), 1'b0, dummy);
    end

    wait_idle();
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/rsde_pkg.sv
rtl/core/rsde_board.sv
rtl/core/raster_shape_draw_engine_top.sv
rtl/core/rsde_checker.sv
tb/raster_shape_draw_engine_top_tb.sv
